@@ hdl/bfbp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfbp_pkg: shared types and constants for the best-fit bin placer
// Field widths, status codes, default parameter values and the structs that
// travel between the controller and the row of bin cells.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int DefMaxBins    = 64;
  localparam int DefWeightBits = 16;

  localparam int WeightW = 16;
  localparam int CapW    = 16;
  localparam int IndexW  = 6;
  localparam int UsedW   = 7;
  localparam int StatusW = 2;

  localparam logic [CapW-1:0] CapReset = 16'hFFFF;

  localparam logic [StatusW-1:0] StPlaced    = 2'd0;
  localparam logic [StatusW-1:0] StBadWeight = 2'd1;
  localparam logic [StatusW-1:0] StNoBin     = 2'd2;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic clear;
    logic add;
    logic open;
  } cell_cmd_t;

  // control part of the search word handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } chain_ctl_t;

endpackage

@@ hdl/bfbp_cell.sv @@
// ----------------------------------------------------------------------------
// bfbp_cell: one bin of the placer
// Holds the load and open flag of one bin. A search word passes through each
// cycle; the cell takes over the best candidate if it fits and is fuller.
// ----------------------------------------------------------------------------
module bfbp_cell #(
  parameter int MAX_BINS    = bfbp_pkg::DefMaxBins,
  parameter int WEIGHT_BITS = bfbp_pkg::DefWeightBits,
  parameter int CELL_INDEX  = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bfbp_pkg::cell_cmd_t         cmd,
  input  logic [$clog2(MAX_BINS)-1:0] cmd_idx,
  input  logic [WEIGHT_BITS-1:0]      weight,
  input  logic [WEIGHT_BITS-1:0]      cap,
  input  bfbp_pkg::chain_ctl_t        in_ctl,
  input  logic [WEIGHT_BITS-1:0]      in_load,
  input  logic [$clog2(MAX_BINS)-1:0] in_idx,
  output bfbp_pkg::chain_ctl_t        out_ctl,
  output logic [WEIGHT_BITS-1:0]      out_load,
  output logic [$clog2(MAX_BINS)-1:0] out_idx
);

  localparam int IdxW = $clog2(MAX_BINS);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_INDEX);

  logic                   bin_open;
  logic [WEIGHT_BITS-1:0] load;
  logic                   hit;
  logic                   fits;
  logic                   take;

  assign hit  = (cmd_idx == MyIdx);
  assign fits = bin_open &&
                (({1'b0, load} + {1'b0, weight}) <= {1'b0, cap});
  assign take = fits && (!in_ctl.found || (load > in_load));

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_open <= 1'b0;
    end else if (cmd.clear) begin
      bin_open <= 1'b0;
    end else if (cmd.open && hit) begin
      bin_open <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open && hit) begin
      load <= weight;
    end else if (cmd.add && hit) begin
      load <= load + weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.found <= in_ctl.found || fits;
    end
  end

  always_ff @(posedge clk) begin
    out_load <= take ? load : in_load;
    out_idx  <= take ? MyIdx : in_idx;
  end

endmodule

@@ hdl/best_fit_bin_placer.sv @@
// ----------------------------------------------------------------------------
// best_fit_bin_placer: best-fit online bin placement
// Places each item in the fullest open bin that still has room, lowest index
// on ties, or opens a fresh bin; flags bad weights and a full bin set.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (item_weight, start_new) is taken at a clock
//   edge where start is high and busy is low. start_new empties every bin
//   before the item is placed.
//   Result: done is high for one cycle with bin_index, bins_used, opened_new
//   and status. The receiver cannot stall; each word is shown once.
//   Config: cfg_data is written to bin_capacity when cfg_valid and cfg_ready
//   are both high; cfg_ready is always high. Write only while idle.
//   Timing: a valid weight is compared against every bin by a search word
//   that walks the row of MAX_BINS cells, one cell per cycle. done is
//   registered when the word leaves the last cell, and busy drops in the
//   same cycle, so items are taken one at a time. A zero or oversized
//   weight is reported in the next cycle.
//   Reset: synchronous rst closes all bins, clears the open count and sets
//   bin_capacity to 65535.
// ----------------------------------------------------------------------------
module best_fit_bin_placer #(
  parameter int MAX_BINS    = bfbp_pkg::DefMaxBins,
  parameter int WEIGHT_BITS = bfbp_pkg::DefWeightBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfbp_pkg::WeightW-1:0]  item_weight,
  input  logic                          start_new,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfbp_pkg::CapW-1:0]     cfg_data,
  output logic                          done,
  output logic [bfbp_pkg::IndexW-1:0]   bin_index,
  output logic [bfbp_pkg::UsedW-1:0]    bins_used,
  output logic                          opened_new,
  output logic [bfbp_pkg::StatusW-1:0]  status
);

  localparam int IdxW = $clog2(MAX_BINS);
  localparam int CntW = $clog2(MAX_BINS + 1);
  localparam logic [CntW-1:0] BinsMax = CntW'(MAX_BINS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                       state, state_next;
  logic [bfbp_pkg::CapW-1:0]    bin_capacity;
  logic [WEIGHT_BITS-1:0]       weight;
  logic [CntW-1:0]              open_cnt;
  logic                         head_valid;

  logic [31:0]                  w_ext;
  logic [31:0]                  cap_ext;
  logic [WEIGHT_BITS-1:0]       w_in;
  logic [WEIGHT_BITS-1:0]       cap;
  logic                         accept;
  logic                         bad;

  bfbp_pkg::cell_cmd_t          cmd;
  logic [IdxW-1:0]              cmd_idx;

  bfbp_pkg::chain_ctl_t         chain_ctl  [0:MAX_BINS];
  logic [WEIGHT_BITS-1:0]       chain_load [0:MAX_BINS];
  logic [IdxW-1:0]              chain_idx  [0:MAX_BINS];

  logic                         decide;
  logic                         can_open;
  logic [IdxW-1:0]              res_idx;
  logic [31:0]                  res_idx_ext;
  logic [31:0]                  used_ext;
  logic [CntW-1:0]              open_cnt_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  assign w_ext   = 32'(item_weight);
  assign cap_ext = 32'(bin_capacity);
  assign w_in    = w_ext[WEIGHT_BITS-1:0];
  assign cap     = cap_ext[WEIGHT_BITS-1:0];
  assign bad     = (w_in == '0) || (w_in > cap);

  assign decide   = (state == S_SCAN) && chain_ctl[MAX_BINS].valid;
  assign can_open = (open_cnt < BinsMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= bfbp_pkg::CapReset;
    end else if (cfg_valid && cfg_ready) begin
      bin_capacity <= cfg_data;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd_idx       = '0;
    res_idx       = '0;
    open_cnt_next = open_cnt;
    if (accept && start_new) begin
      cmd.clear     = 1'b1;
      open_cnt_next = '0;
    end
    if (decide) begin
      if (chain_ctl[MAX_BINS].found) begin
        cmd.add = 1'b1;
        cmd_idx = chain_idx[MAX_BINS];
        res_idx = chain_idx[MAX_BINS];
      end else if (can_open) begin
        cmd.open      = 1'b1;
        cmd_idx       = open_cnt[IdxW-1:0];
        res_idx       = open_cnt[IdxW-1:0];
        open_cnt_next = open_cnt + 1'b1;
      end
    end
  end

  assign res_idx_ext = 32'(res_idx);
  assign used_ext    = 32'(open_cnt_next);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !bad) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (decide) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_cnt   <= '0;
      head_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      open_cnt   <= open_cnt_next;
      head_valid <= accept && !bad;
      done       <= (accept && bad) || decide;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      weight <= w_in;
    end
    if (accept && bad) begin
      bin_index  <= '0;
      bins_used  <= used_ext[bfbp_pkg::UsedW-1:0];
      opened_new <= 1'b0;
      status     <= bfbp_pkg::StBadWeight;
    end else if (decide) begin
      bins_used <= used_ext[bfbp_pkg::UsedW-1:0];
      if (chain_ctl[MAX_BINS].found || can_open) begin
        bin_index  <= res_idx_ext[bfbp_pkg::IndexW-1:0];
        opened_new <= !chain_ctl[MAX_BINS].found;
        status     <= bfbp_pkg::StPlaced;
      end else begin
        bin_index  <= '0;
        opened_new <= 1'b0;
        status     <= bfbp_pkg::StNoBin;
      end
    end
  end

  assign chain_ctl[0]  = '{valid: head_valid, found: 1'b0};
  assign chain_load[0] = '0;
  assign chain_idx[0]  = '0;

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    bfbp_cell #(
      .MAX_BINS    (MAX_BINS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .weight   (weight),
      .cap      (cap),
      .in_ctl   (chain_ctl[i]),
      .in_load  (chain_load[i]),
      .in_idx   (chain_idx[i]),
      .out_ctl  (chain_ctl[i+1]),
      .out_load (chain_load[i+1]),
      .out_idx  (chain_idx[i+1])
    );
  end

endmodule
